/* design/bff_pkg.sv */
// Shared widths, register indexes and reset values of the brush footprint block.
package bff_pkg;

	// Field widths
	localparam int CENTER_W = 16;
	localparam int MODE_W   = 2;
	localparam int GRID_W   = 16;
	localparam int WEIGHT_W = 9;
	localparam int DELTA_W  = 17;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SHAPE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPACING  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SOFTNESS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd4;

	localparam int SIZE_W    = 10;
	localparam int SPACING_W = 8;
	localparam int SOFT_W    = 9;
	localparam int GAIN_W    = 16;

	localparam logic               RST_SHAPE    = 1'b0;
	localparam logic [SIZE_W-1:0]    RST_SIZE     = 10'd64;
	localparam logic [SPACING_W-1:0] RST_SPACING  = 8'd16;
	localparam logic [SOFT_W-1:0]    RST_SOFTNESS = 9'd0;
	localparam logic [GAIN_W-1:0]    RST_GAIN     = 16'd256;

	// Mode codes
	localparam logic [MODE_W-1:0] MODE_RAISE    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOWER    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_EQUALIZE = 2'd2;

	// Weight of a point at full strength, Q1.8
	localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 9'd256;
	// Smallest softness that gives a soft edge
	localparam logic [SOFT_W-1:0]   SOFT_MIN    = 9'd3;

	localparam int MAX_SPAN_DEF = 8;

endpackage

/* design/bff_if.sv */
// Valid/ready channel interfaces for brush placements and footprint points.
interface bff_place_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [bff_pkg::CENTER_W-1:0]   center_x;
	logic signed [bff_pkg::CENTER_W-1:0]   center_y;
	logic        [bff_pkg::MODE_W-1:0]     mode;

	modport source (output valid, center_x, center_y, mode, input ready);
	modport sink   (input valid, center_x, center_y, mode, output ready);
endinterface

interface bff_point_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [bff_pkg::GRID_W-1:0]     grid_x;
	logic signed [bff_pkg::GRID_W-1:0]     grid_y;
	logic        [bff_pkg::WEIGHT_W-1:0]   weight;
	logic signed [bff_pkg::DELTA_W-1:0]    height_delta;
	logic                                  clipped;
	logic                                  last;

	modport source (output valid, grid_x, grid_y, weight, height_delta, clipped, last,
		input ready);
	modport sink   (input valid, grid_x, grid_y, weight, height_delta, clipped, last,
		output ready);
endinterface

/* design/brush_footprint_falloff.sv */
// Terrain brush footprint walker with falloff weights, built on one shared divider.
//
// One placement (centre in world units and a mode) is accepted when the block is idle,
// then the grid points of the brush's bounding box are produced row by row, y outer and
// x inner, one item per point, the final one flagged with last. Each axis is clipped to
// MAX_SPAN points, which sets clipped on every point of that placement. Equalize and
// mode 3 produce nothing and keep the block idle, ready for the next placement on the
// following cycle. All work runs
// through one restoring divider (one quotient bit a cycle), one shift-and-subtract square
// root (one result bit a cycle) and one registered 18x18 multiplier, sequenced by a
// single state machine; the block accepts no placement until the last point is taken.
// Box setup runs the four bound divides. Each point then passes through the multiplier
// states and the handshake when its weight is zero or full; a soft square point adds the
// edge divide; a soft circle point adds the falloff divide and the root; a point inside
// the soft band adds the softness divide as well.
// Configuration writes must happen only while idle.
module brush_footprint_falloff #(
	parameter int MAX_SPAN = bff_pkg::MAX_SPAN_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [bff_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bff_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	bff_place_if.sink                         placement,
	bff_point_if.source                       point
);
	import bff_pkg::*;

	localparam int SPAN_W = $clog2(MAX_SPAN + 1);
	localparam int H_W    = SIZE_W - 1;  // half size
	localparam int G_W    = 18;          // box bounds and grid coordinates
	localparam int SPN_W  = G_W + 1;     // span before clipping
	localparam int DX_W   = 13;          // offsets stay within about two spacings of the box
	localparam int SQ_W   = 23;          // squared distance
	localparam int HH_W   = 2 * H_W;
	localparam int MUL_W  = 18;
	localparam int PRD_W  = 2 * MUL_W;
	localparam int NUM_W  = 34;          // widest dividend: (h*h - D) << 16
	localparam int DEN_W  = 18;
	localparam int Q_W    = 17;          // every quotient fits here
	localparam int CNT_W  = $clog2(NUM_W + 1);
	localparam int SQR_W  = 17;          // root operand up to 65536

	typedef enum logic [3:0] {
		S_IDLE, S_BOX, S_DIV, S_SPAN, S_HH, S_PX, S_PY, S_SQX, S_SQY,
		S_EVAL, S_SQRT, S_SOFT, S_GAIN, S_DELTA, S_OUT
	} state_t;

	typedef enum logic [2:0] {
		OP_X0, OP_X1, OP_Y0, OP_Y1, OP_F, OP_SQR, OP_SOFT
	} div_op_t;

	// Configuration registers
	logic                 shape_q;
	logic [SIZE_W-1:0]    size_q;
	logic [SPACING_W-1:0] spacing_q;
	logic [SOFT_W-1:0]    soft_q;
	logic [GAIN_W-1:0]    gain_q;

	// Placement and walk state
	state_t                    state_q;
	div_op_t                   op_q;
	logic signed [CENTER_W-1:0] cx_q, cy_q;
	logic                      lower_q;
	logic signed [G_W-1:0]     x0_q, x1_q, y0_q, y1_q;
	logic [SPAN_W-1:0]         nx_q, ny_q, xi_q, yi_q;
	logic                      clip_q;
	logic [HH_W-1:0]           hh_q;
	logic signed [DX_W-1:0]    dx_q, dy_q;
	logic [SQ_W-1:0]           sqx_q;
	logic [WEIGHT_W-1:0]       w_q;
	logic [WEIGHT_W-1:0]       r_q;
	logic signed [PRD_W-1:0]   prod_q;

	// Divider and root unit registers
	logic [NUM_W-1:0]  div_num_q;
	logic [DEN_W-1:0]  div_den_q;
	logic [DEN_W-1:0]  div_rem_q;
	logic [CNT_W-1:0]  div_cnt_q;
	logic              div_neg_q;
	logic [SQR_W-1:0]  sq_v_q, sq_res_q, sq_bit_q;

	// Output register
	logic                      out_valid_q;
	logic signed [GRID_W-1:0]  out_gx_q, out_gy_q;
	logic [WEIGHT_W-1:0]       out_w_q;
	logic signed [DELTA_W-1:0] out_delta_q;
	logic                      out_clip_q, out_last_q;

	// Derived values
	logic [H_W-1:0]       h;
	logic [SPACING_W-1:0] s;
	logic                 soft_on;
	logic signed [G_W-1:0] gx, gy;
	logic signed [G_W-1:0] nx0, nx1, ny0, ny1;
	logic signed [SPN_W-1:0] spanx, spany;
	logic [SQ_W-1:0]      dsq;
	logic [DX_W-1:0]      adx, ady, mx;
	logic                 last_pt;
	logic signed [MUL_W-1:0] mul_a, mul_b;

	// Divider step
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W+1:0] rem_diff;
	logic [DEN_W-1:0] rem_nx;
	logic [NUM_W-1:0] num_nx;
	logic [Q_W-1:0]   quo;
	logic signed [G_W-1:0] box_q;

	// Root step
	logic [SQR_W:0]   sq_sum;
	logic [SQR_W-1:0] sq_v_nx, sq_res_nx;

	// Delta
	logic [DELTA_W-1:0] delta_mag;

	assign h       = size_q[SIZE_W-1:1];
	assign s       = (spacing_q == '0) ? SPACING_W'(1) : spacing_q;
	assign soft_on = (soft_q >= SOFT_MIN);

	assign gx = x0_q + G_W'(xi_q);
	assign gy = y0_q + G_W'(yi_q);

	// Box numerators: start uses c - h, end uses c + h + s
	assign nx0 = G_W'(cx_q) - G_W'(h);
	assign nx1 = G_W'(cx_q) + G_W'(h) + G_W'(s);
	assign ny0 = G_W'(cy_q) - G_W'(h);
	assign ny1 = G_W'(cy_q) + G_W'(h) + G_W'(s);

	assign spanx = SPN_W'(x1_q) - SPN_W'(x0_q) + SPN_W'(1);
	assign spany = SPN_W'(y1_q) - SPN_W'(y0_q) + SPN_W'(1);

	assign dsq = sqx_q + prod_q[SQ_W-1:0];
	assign adx = dx_q[DX_W-1] ? DX_W'(-dx_q) : DX_W'(dx_q);
	assign ady = dy_q[DX_W-1] ? DX_W'(-dy_q) : DX_W'(dy_q);
	assign mx  = (adx > ady) ? adx : ady;

	assign last_pt = (xi_q == nx_q - SPAN_W'(1)) && (yi_q == ny_q - SPAN_W'(1));

	// Shared multiplier operands, chosen by state
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_SPAN: begin
				mul_a = MUL_W'(h);
				mul_b = MUL_W'(h);
			end
			S_PX: begin
				mul_a = gx;
				mul_b = MUL_W'(s);
			end
			S_PY: begin
				mul_a = gy;
				mul_b = MUL_W'(s);
			end
			S_SQX: begin
				mul_a = MUL_W'(dx_q);
				mul_b = MUL_W'(dx_q);
			end
			S_SQY: begin
				mul_a = MUL_W'(dy_q);
				mul_b = MUL_W'(dy_q);
			end
			S_GAIN: begin
				mul_a = MUL_W'(w_q);
				mul_b = MUL_W'(gain_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Restoring divide: one quotient bit per cycle, quotient shifts into the dividend
	always_comb begin
		rem_sh   = {div_rem_q, div_num_q[NUM_W-1]};
		rem_diff = {1'b0, rem_sh} - {2'b00, div_den_q};
		if (!rem_diff[DEN_W+1]) begin
			rem_nx = rem_diff[DEN_W-1:0];
			num_nx = {div_num_q[NUM_W-2:0], 1'b1};
		end else begin
			rem_nx = rem_sh[DEN_W-1:0];
			num_nx = {div_num_q[NUM_W-2:0], 1'b0};
		end
		quo   = num_nx[Q_W-1:0];
		box_q = div_neg_q ? -G_W'(quo) : G_W'(quo);
	end

	// Square root: one result bit per cycle
	always_comb begin
		sq_sum = {1'b0, sq_res_q} + {1'b0, sq_bit_q};
		if ({1'b0, sq_v_q} >= sq_sum) begin
			sq_v_nx   = sq_v_q - sq_sum[SQR_W-1:0];
			sq_res_nx = (sq_res_q >> 1) + sq_bit_q;
		end else begin
			sq_v_nx   = sq_v_q;
			sq_res_nx = sq_res_q >> 1;
		end
	end

	assign delta_mag = prod_q[DELTA_W+7:8];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q   <= RST_SHAPE;
			size_q    <= RST_SIZE;
			spacing_q <= RST_SPACING;
			soft_q    <= RST_SOFTNESS;
			gain_q    <= RST_GAIN;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SHAPE:    shape_q   <= cfg_wdata[0];
				REG_SIZE:     size_q    <= cfg_wdata[SIZE_W-1:0];
				REG_SPACING:  spacing_q <= cfg_wdata[SPACING_W-1:0];
				REG_SOFTNESS: soft_q    <= cfg_wdata[SOFT_W-1:0];
				REG_GAIN:     gain_q    <= cfg_wdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Payload registers of the multiplier; no reset needed
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Sequencer: holds state, the arithmetic unit registers and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_X0;
			out_valid_q <= 1'b0;
			cx_q        <= '0;
			cy_q        <= '0;
			lower_q     <= 1'b0;
			x0_q        <= '0;
			x1_q        <= '0;
			y0_q        <= '0;
			y1_q        <= '0;
			nx_q        <= '0;
			ny_q        <= '0;
			xi_q        <= '0;
			yi_q        <= '0;
			clip_q      <= 1'b0;
			hh_q        <= '0;
			dx_q        <= '0;
			dy_q        <= '0;
			sqx_q       <= '0;
			w_q         <= '0;
			r_q         <= '0;
			div_num_q   <= '0;
			div_den_q   <= '0;
			div_rem_q   <= '0;
			div_cnt_q   <= '0;
			div_neg_q   <= 1'b0;
			sq_v_q      <= '0;
			sq_res_q    <= '0;
			sq_bit_q    <= '0;
			out_gx_q    <= '0;
			out_gy_q    <= '0;
			out_w_q     <= '0;
			out_delta_q <= '0;
			out_clip_q  <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (placement.valid) begin
						cx_q    <= placement.center_x;
						cy_q    <= placement.center_y;
						lower_q <= (placement.mode == MODE_LOWER);
						// equalize and the unused code produce nothing
						if (placement.mode != MODE_RAISE && placement.mode != MODE_LOWER)
							state_q <= S_IDLE;
						else
							state_q <= S_BOX;
					end
				end
				S_BOX: begin
					// start the x start bound divide
					div_neg_q <= nx0[G_W-1];
					div_num_q <= {(nx0[G_W-1] ? Q_W'(-nx0) : Q_W'(nx0)), Q_W'(0)};
					div_den_q <= DEN_W'(s);
					div_rem_q <= '0;
					div_cnt_q <= CNT_W'(Q_W);
					op_q      <= OP_X0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					if (div_cnt_q == CNT_W'(1)) begin
						div_rem_q <= '0;
						unique case (op_q)
							OP_X0: begin
								x0_q      <= box_q;
								div_neg_q <= nx1[G_W-1];
								div_num_q <= {(nx1[G_W-1] ? Q_W'(-nx1) : Q_W'(nx1)),
									Q_W'(0)};
								div_cnt_q <= CNT_W'(Q_W);
								op_q      <= OP_X1;
							end
							OP_X1: begin
								x1_q      <= box_q;
								div_neg_q <= ny0[G_W-1];
								div_num_q <= {(ny0[G_W-1] ? Q_W'(-ny0) : Q_W'(ny0)),
									Q_W'(0)};
								div_cnt_q <= CNT_W'(Q_W);
								op_q      <= OP_Y0;
							end
							OP_Y0: begin
								y0_q      <= box_q;
								div_neg_q <= ny1[G_W-1];
								div_num_q <= {(ny1[G_W-1] ? Q_W'(-ny1) : Q_W'(ny1)),
									Q_W'(0)};
								div_cnt_q <= CNT_W'(Q_W);
								op_q      <= OP_Y1;
							end
							OP_Y1: begin
								y1_q    <= box_q;
								state_q <= S_SPAN;
							end
							OP_F: begin
								// falloff fraction in Q1.16, take its root
								sq_v_q   <= quo;
								sq_res_q <= '0;
								sq_bit_q <= SQR_W'(1) << (SQR_W - 1);
								state_q  <= S_SQRT;
							end
							OP_SQR: begin
								r_q     <= quo[WEIGHT_W-1:0];
								state_q <= S_SOFT;
							end
							OP_SOFT: begin
								w_q     <= quo[WEIGHT_W-1:0];
								state_q <= S_GAIN;
							end
							default: state_q <= S_IDLE;
						endcase
					end else begin
						div_num_q <= num_nx;
						div_rem_q <= rem_nx;
						div_cnt_q <= div_cnt_q - CNT_W'(1);
					end
				end
				S_SPAN: begin
					// clip each axis; the multiplier forms h*h this cycle
					clip_q <= (spanx > SPN_W'(MAX_SPAN)) || (spany > SPN_W'(MAX_SPAN));
					if (spanx > SPN_W'(MAX_SPAN)) begin
						nx_q <= SPAN_W'(MAX_SPAN);
					end else begin
						nx_q <= SPAN_W'(spanx);
					end
					if (spany > SPN_W'(MAX_SPAN)) begin
						ny_q <= SPAN_W'(MAX_SPAN);
					end else begin
						ny_q <= SPAN_W'(spany);
					end
					xi_q    <= '0;
					yi_q    <= '0;
					state_q <= S_HH;
				end
				S_HH: begin
					hh_q    <= prod_q[HH_W-1:0];
					state_q <= S_PX;
				end
				S_PX: state_q <= S_PY;
				S_PY: begin
					dx_q    <= prod_q[DX_W-1:0] - cx_q[DX_W-1:0];
					state_q <= S_SQX;
				end
				S_SQX: begin
					dy_q    <= prod_q[DX_W-1:0] - cy_q[DX_W-1:0];
					state_q <= S_SQY;
				end
				S_SQY: begin
					sqx_q   <= prod_q[SQ_W-1:0];
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					div_rem_q <= '0;
					if (!shape_q) begin
						if (dsq > SQ_W'(hh_q)) begin
							w_q     <= '0;
							state_q <= S_GAIN;
						end else if (soft_on && h != '0) begin
							div_num_q <= NUM_W'(hh_q - HH_W'(dsq)) << 16;
							div_den_q <= DEN_W'(hh_q);
							div_cnt_q <= CNT_W'(NUM_W);
							op_q      <= OP_F;
							state_q   <= S_DIV;
						end else begin
							w_q     <= WEIGHT_FULL;
							state_q <= S_GAIN;
						end
					end else begin
						if (mx > DX_W'(h)) begin
							w_q     <= '0;
							state_q <= S_GAIN;
						end else if (soft_on && h != '0) begin
							div_num_q <= {Q_W'(H_W'(h - H_W'(mx))) << 8, Q_W'(0)};
							div_den_q <= DEN_W'(h);
							div_cnt_q <= CNT_W'(Q_W);
							op_q      <= OP_SQR;
							state_q   <= S_DIV;
						end else begin
							w_q     <= WEIGHT_FULL;
							state_q <= S_GAIN;
						end
					end
				end
				S_SQRT: begin
					sq_v_q   <= sq_v_nx;
					sq_res_q <= sq_res_nx;
					sq_bit_q <= sq_bit_q >> 2;
					if (sq_bit_q[0]) begin
						r_q     <= sq_res_nx[WEIGHT_W-1:0];
						state_q <= S_SOFT;
					end
				end
				S_SOFT: begin
					// scale down inside the soft band
					if (r_q < soft_q) begin
						div_num_q <= {Q_W'(r_q) << 8, Q_W'(0)};
						div_den_q <= DEN_W'(soft_q);
						div_rem_q <= '0;
						div_cnt_q <= CNT_W'(Q_W);
						op_q      <= OP_SOFT;
						state_q   <= S_DIV;
					end else begin
						w_q     <= WEIGHT_FULL;
						state_q <= S_GAIN;
					end
				end
				S_GAIN: state_q <= S_DELTA;
				S_DELTA: begin
					out_gx_q    <= gx[GRID_W-1:0];
					out_gy_q    <= gy[GRID_W-1:0];
					out_w_q     <= w_q;
					out_delta_q <= lower_q ? -$signed(delta_mag) : $signed(delta_mag);
					out_clip_q  <= clip_q;
					out_last_q  <= last_pt;
					out_valid_q <= 1'b1;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (point.ready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							state_q <= S_IDLE;
						end else begin
							if (xi_q == nx_q - SPAN_W'(1)) begin
								xi_q <= '0;
								yi_q <= yi_q + SPAN_W'(1);
							end else begin
								xi_q <= xi_q + SPAN_W'(1);
							end
							state_q <= S_PX;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign placement.ready    = (state_q == S_IDLE);
	assign point.valid        = out_valid_q;
	assign point.grid_x       = out_gx_q;
	assign point.grid_y       = out_gy_q;
	assign point.weight       = out_w_q;
	assign point.height_delta = out_delta_q;
	assign point.clipped      = out_clip_q;
	assign point.last         = out_last_q;

`ifndef SYNTHESIS
	a_out_only_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		point.valid |-> state_q == S_OUT)
		else $error("point shown outside the output state");
	a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		placement.ready |-> !point.valid)
		else $error("placement accepted while a point is pending");
	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		point.valid |-> point.weight <= WEIGHT_FULL)
		else $error("weight above full strength");
	a_zero_weight_delta: assert property (@(posedge clk) disable iff (!arst_n)
		point.valid && point.weight == '0 |-> point.height_delta == '0)
		else $error("nonzero delta on a zero-weight point");
	a_last_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		point.valid && point.ready && point.last |=> state_q == S_IDLE)
		else $error("walk did not end after the last point");
`endif

endmodule
